/* rtl/asld_pkg.sv */
// Shared types, constants and codes for the accelerometer shake and lift detector.
package asld_pkg;

	// Sample format and ring size
	localparam int SAMPLE_BITS = 16;
	localparam int ONE_G       = 4096;
	localparam int PEAK_SLOTS  = 8;

	// Derived widths
	localparam int SLOT_W   = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
	localparam int CNT_W    = $clog2(PEAK_SLOTS + 1);
	localparam int PCMP_W   = (CNT_W > 4) ? CNT_W : 4;
	localparam int SQ_W     = 2 * SAMPLE_BITS;        // one axis square
	localparam int MAG_W    = 2 * SAMPLE_BITS;        // sum of three axis squares
	localparam int DSQ_W    = 2 * SAMPLE_BITS + 2;    // one delta square (signed product)
	localparam int DSUM_W   = 2 * SAMPLE_BITS + 2;    // sum of three delta squares
	localparam int BAND_W   = 17;                     // ONE_G +/- threshold
	localparam int BSQ_W    = 2 * BAND_W;
	localparam int CMP_SQ_W = (DSUM_W > BSQ_W) ? DSUM_W : BSQ_W;

	// Stream payload widths
	localparam int IN_W  = 3 * SAMPLE_BITS + 32;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TW = 8;

	// Register map (word index)
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MOTION_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_REARM_STILL      = 3'd1;
	localparam logic [2:0] REG_LIFT_SAMPLES     = 3'd2;
	localparam logic [2:0] REG_SHAKE_PEAKS      = 3'd3;
	localparam logic [2:0] REG_SHAKE_WINDOW     = 3'd4;
	localparam logic [2:0] REG_EVENT_COOLDOWN   = 3'd5;

	// Event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHAKE = 2'd1;
	localparam logic [1:0] EV_LIFT  = 2'd2;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [14:0]      motion_threshold;
		logic [7:0]       rearm_still_samples;
		logic [7:0]       lift_samples;
		logic [3:0]       shake_peaks;
		logic [15:0]      peak_window_ms;
		logic [19:0]      event_cooldown_ms;
		logic [BSQ_W-1:0] thr_sq;
		logic [BSQ_W-1:0] hi_sq;
		logic [BSQ_W-1:0] lo_sq;
		logic             lo_pos;
	} cfg_t;

endpackage

/* rtl/asld_cfg.sv */
// APB register file and registered threshold squares for the detector.
module asld_cfg import asld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [14:0] thr_q;
	logic [7:0]  rearm_q;
	logic [7:0]  lift_q;
	logic [3:0]  peaks_q;
	logic [15:0] window_q;
	logic [19:0] cool_q;
	logic [BSQ_W-1:0] thr_sq_q;
	logic [BSQ_W-1:0] hi_sq_q;
	logic [BSQ_W-1:0] lo_sq_q;
	logic             lo_pos_q;
	logic [BAND_W-1:0] hi;
	logic [BAND_W-1:0] lo;
	logic [2:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 15'd1229;
			rearm_q  <= 8'd50;
			lift_q   <= 8'd5;
			peaks_q  <= 4'd2;
			window_q <= 16'd1000;
			cool_q   <= 20'd30000;
		end else if (wr) begin
			unique case (idx)
				REG_MOTION_THRESHOLD: thr_q    <= pwdata[14:0];
				REG_REARM_STILL:      rearm_q  <= pwdata[7:0];
				REG_LIFT_SAMPLES:     lift_q   <= pwdata[7:0];
				REG_SHAKE_PEAKS:      peaks_q  <= pwdata[3:0];
				REG_SHAKE_WINDOW:     window_q <= pwdata[15:0];
				REG_EVENT_COOLDOWN:   cool_q   <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_MOTION_THRESHOLD: prdata = {17'd0, thr_q};
			REG_REARM_STILL:      prdata = {24'd0, rearm_q};
			REG_LIFT_SAMPLES:     prdata = {24'd0, lift_q};
			REG_SHAKE_PEAKS:      prdata = {28'd0, peaks_q};
			REG_SHAKE_WINDOW:     prdata = {16'd0, window_q};
			REG_EVENT_COOLDOWN:   prdata = {12'd0, cool_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Band edges; lower edge only exists while threshold is below one g
	assign hi = BAND_W'(ONE_G) + BAND_W'(thr_q);
	assign lo = BAND_W'(ONE_G) - BAND_W'(thr_q);

	// Squares are registered, so they follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_pos_q <= 1'b1;
		end else begin
			lo_pos_q <= (BAND_W'(thr_q) < BAND_W'(ONE_G));
		end
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= BSQ_W'(thr_q) * BSQ_W'(thr_q);
		hi_sq_q  <= BSQ_W'(hi) * BSQ_W'(hi);
		lo_sq_q  <= BSQ_W'(lo) * BSQ_W'(lo);
	end

	assign cfg.motion_threshold    = thr_q;
	assign cfg.rearm_still_samples = rearm_q;
	assign cfg.lift_samples        = lift_q;
	assign cfg.shake_peaks         = peaks_q;
	assign cfg.peak_window_ms      = window_q;
	assign cfg.event_cooldown_ms   = cool_q;
	assign cfg.thr_sq              = thr_sq_q;
	assign cfg.hi_sq               = hi_sq_q;
	assign cfg.lo_sq               = lo_sq_q;
	assign cfg.lo_pos              = lo_pos_q;

endmodule

/* rtl/accel_shake_lift_detector.sv */
// Top level of the accelerometer shake and lift detector.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: accel_x, accel_y, accel_z, time_ms
//  m_      | out | m_tvalid/m_tready  | m_tdata: event_kind, is_moving, is_armed
//  apb     | in  | psel/penable       | paddr, pwdata, prdata; six registers
//
// One sample per cycle sustained while the output is not stalled; the input register
// feeds the axis squares, then squared sums and compares, then the state update with
// the eight parallel peak-age compares into the output register.
// Reset (arst_n) clears all detector state, the peak ring and the pipeline.
// A stalled result holds in the output register; the pipeline keeps filling
// until every stage is occupied, then s_tready drops.
module accel_shake_lift_detector import asld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,   // accel_x, accel_y, accel_z, time_ms
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,   // event_kind[1:0], is_moving, is_armed, zero pad
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SB = SAMPLE_BITS;

	cfg_t cfg;

	asld_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline control
	logic v_s1, v_s2, v_s3, out_v_q;
	logic adv1, adv2, adv3, s_acc;

	assign adv3     = v_s3 && (!out_v_q || m_tready);
	assign adv2     = v_s2 && (!v_s3 || adv3);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || adv1;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_acc)     v_s1 <= 1'b1;
			else if (adv1) v_s1 <= 1'b0;
			if (adv1)      v_s2 <= 1'b1;
			else if (adv2) v_s2 <= 1'b0;
			if (adv2)      v_s3 <= 1'b1;
			else if (adv3) v_s3 <= 1'b0;
			if (adv3)          out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	// Stage 1: input register
	logic signed [SB-1:0] x_s1, y_s1, z_s1;
	logic [31:0]          time_s1;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_s1    <= s_tdata[SB-1:0];
			y_s1    <= s_tdata[2*SB-1:SB];
			z_s1    <= s_tdata[3*SB-1:2*SB];
			time_s1 <= s_tdata[3*SB+31:3*SB];
		end
	end

	// Previous sample, updated in request order
	logic signed [SB-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                 prev_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			prev_valid_q <= 1'b0;
		end else if (adv1) begin
			prev_x_q     <= x_s1;
			prev_y_q     <= y_s1;
			prev_z_q     <= z_s1;
			prev_valid_q <= 1'b1;
		end
	end

	// Axis and delta squares
	logic signed [SB:0]      dx, dy, dz;
	logic signed [SQ_W-1:0]  px, py, pz;
	logic signed [DSQ_W-1:0] pdx, pdy, pdz;

	assign dx  = $signed({x_s1[SB-1], x_s1}) - $signed({prev_x_q[SB-1], prev_x_q});
	assign dy  = $signed({y_s1[SB-1], y_s1}) - $signed({prev_y_q[SB-1], prev_y_q});
	assign dz  = $signed({z_s1[SB-1], z_s1}) - $signed({prev_z_q[SB-1], prev_z_q});
	assign px  = SQ_W'(x_s1) * SQ_W'(x_s1);
	assign py  = SQ_W'(y_s1) * SQ_W'(y_s1);
	assign pz  = SQ_W'(z_s1) * SQ_W'(z_s1);
	assign pdx = DSQ_W'(dx) * DSQ_W'(dx);
	assign pdy = DSQ_W'(dy) * DSQ_W'(dy);
	assign pdz = DSQ_W'(dz) * DSQ_W'(dz);

	// Stage 2: squares
	logic [SQ_W-1:0]  sx_s2, sy_s2, sz_s2;
	logic [DSQ_W-1:0] sdx_s2, sdy_s2, sdz_s2;
	logic             pv_s2;
	logic [31:0]      time_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			sx_s2   <= $unsigned(px);
			sy_s2   <= $unsigned(py);
			sz_s2   <= $unsigned(pz);
			sdx_s2  <= $unsigned(pdx);
			sdy_s2  <= $unsigned(pdy);
			sdz_s2  <= $unsigned(pdz);
			pv_s2   <= prev_valid_q;
			time_s2 <= time_s1;
		end
	end

	// Sums and moving classification
	logic [CMP_SQ_W-1:0] mag_sum, d_sum;
	logic                moving;

	assign mag_sum = CMP_SQ_W'(sx_s2) + CMP_SQ_W'(sy_s2) + CMP_SQ_W'(sz_s2);
	assign d_sum   = CMP_SQ_W'(sdx_s2) + CMP_SQ_W'(sdy_s2) + CMP_SQ_W'(sdz_s2);
	assign moving  = (pv_s2 && (d_sum > CMP_SQ_W'(cfg.thr_sq)))
		|| (mag_sum > CMP_SQ_W'(cfg.hi_sq))
		|| (cfg.lo_pos && (mag_sum < CMP_SQ_W'(cfg.lo_sq)));

	// Stage 3: classification
	logic        moving_s3;
	logic [31:0] time_s3;

	always_ff @(posedge clk) begin
		if (adv2) begin
			moving_s3 <= moving;
			time_s3   <= time_s2;
		end
	end

	// Detector state
	logic              armed_q;
	logic [7:0]        lift_q;
	logic [7:0]        still_q;
	logic [31:0]       peak_q [PEAK_SLOTS];
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       cool_until_q;

	// Next-state logic
	logic [31:0]       slot_val [PEAK_SLOTS];
	logic [31:0]       age [PEAK_SLOTS];
	logic [PEAK_SLOTS-1:0] hit;
	logic [CNT_W-1:0]  peak_cnt;
	logic [7:0]        lift_inc, still_inc;
	logic              active, shake, lift;
	logic              armed_d, clear_ring, write_ring;
	logic [7:0]        lift_d, still_d;
	logic [SLOT_W-1:0] slot_d;
	logic [31:0]       cool_d;
	logic [1:0]        ev_d;

	always_comb begin
		active = moving_s3 && armed_q && (time_s3 >= cool_until_q);
		// peak ages, with this sample already in its slot
		for (int i = 0; i < PEAK_SLOTS; i++) begin
			slot_val[i] = (slot_q == SLOT_W'(i)) ? time_s3 : peak_q[i];
			age[i]      = time_s3 - slot_val[i];
			hit[i]      = (slot_val[i] != 32'd0) && (age[i] < {16'd0, cfg.peak_window_ms});
		end
		peak_cnt  = CNT_W'($countones(hit));
		shake     = active && (PCMP_W'(peak_cnt) >= PCMP_W'(cfg.shake_peaks));
		lift_inc  = (lift_q == 8'hFF) ? 8'hFF : lift_q + 8'd1;
		still_inc = (still_q == 8'hFF) ? 8'hFF : still_q + 8'd1;
		lift      = active && !shake && (lift_inc >= cfg.lift_samples);

		armed_d    = armed_q;
		lift_d     = lift_q;
		still_d    = still_q;
		slot_d     = slot_q;
		cool_d     = cool_until_q;
		clear_ring = 1'b0;
		write_ring = 1'b0;
		ev_d       = EV_NONE;

		if (!moving_s3) begin
			still_d    = still_inc;
			lift_d     = 8'd0;
			clear_ring = 1'b1;
			if (still_inc >= cfg.rearm_still_samples) armed_d = 1'b1;
		end else begin
			still_d = 8'd0;
			if (active) begin
				write_ring = 1'b1;
				slot_d     = (slot_q == SLOT_W'(PEAK_SLOTS - 1)) ? '0 : slot_q + 1'b1;
				if (shake) begin
					armed_d    = 1'b0;
					lift_d     = 8'd0;
					cool_d     = time_s3 + {12'd0, cfg.event_cooldown_ms};
					clear_ring = 1'b1;
					ev_d       = EV_SHAKE;
				end else if (lift) begin
					armed_d = 1'b0;
					lift_d  = 8'd0;
					cool_d  = time_s3 + {12'd0, cfg.event_cooldown_ms};
					ev_d    = EV_LIFT;
				end else begin
					lift_d = lift_inc;
				end
			end
		end
	end

	// State update, in step with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b1;
			lift_q       <= 8'd0;
			still_q      <= 8'd0;
			slot_q       <= '0;
			cool_until_q <= 32'd0;
			for (int i = 0; i < PEAK_SLOTS; i++) peak_q[i] <= 32'd0;
		end else if (adv3) begin
			armed_q      <= armed_d;
			lift_q       <= lift_d;
			still_q      <= still_d;
			slot_q       <= slot_d;
			cool_until_q <= cool_d;
			if (clear_ring) begin
				for (int i = 0; i < PEAK_SLOTS; i++) peak_q[i] <= 32'd0;
			end else if (write_ring) begin
				peak_q[slot_q] <= time_s3;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv3) m_tdata <= {4'd0, armed_d, moving_s3, ev_d};
	end

endmodule

/* rtl/asld_checker.sv */
// Port-level assertions for the detector, bound to the top level.
module asld_checker import asld_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata,
	input logic              pready
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only defined event codes appear
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == EV_NONE || m_tdata[1:0] == EV_SHAKE
			|| m_tdata[1:0] == EV_LIFT))
		else $error("bad event code");

	// An event comes only from a moving sample and leaves the block disarmed
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != EV_NONE) |-> m_tdata[2] && !m_tdata[3])
		else $error("event without motion or still armed");

	// Register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind accel_shake_lift_detector asld_checker u_asld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

/* tb/testbench.sv */
// Self-checking testbench for the accelerometer shake and lift detector.
module testbench;
	import asld_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	// One sample request, x in the lowest bits
	typedef struct packed {
		logic [31:0]                   t;
		logic signed [SAMPLE_BITS-1:0] z;
		logic signed [SAMPLE_BITS-1:0] y;
		logic signed [SAMPLE_BITS-1:0] x;
	} sample_t;

	// One result, event kind in the lowest bits
	typedef struct packed {
		logic [OUT_TW-5:0] pad;
		logic              armed;
		logic              moving;
		logic [1:0]        ev;
	} status_t;

	// Directed row: sample, then the typed result where chk is set
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] y;
		logic signed [SAMPLE_BITS-1:0] z;
		logic [31:0]                   t;
		logic                          chk;
		logic [1:0]                    ev;
		logic                          mv;
		logic                          arm;
	} dir_row_t;

	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata;   // accel_x, accel_y, accel_z, time_ms
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_TW-1:0] m_tdata;   // event_kind[1:0], is_moving, is_armed, zero pad
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Register copies seen by the predictor
	int unsigned cfg_thr, cfg_rearm, cfg_lift, cfg_peaks, cfg_window, cfg_cooldown;

	// Predicted detector state
	logic signed [SAMPLE_BITS-1:0] last_x, last_y, last_z;
	bit                            have_last;
	bit                            arm_q;
	int unsigned                   lift_cnt, still_cnt;
	logic [31:0]                   peak_ring [PEAK_SLOTS];
	int unsigned                   ring_ptr;
	logic [31:0]                   quiet_until;

	status_t     status_due [$];
	int          err_count = 0;
	int          result_count = 0;
	int          cycle_count = 0;
	int          hold_asks = 0;
	int          burst_left = 0;
	logic [31:0] g_time;

	dir_row_t dir_rows [0:16] = '{
		'{0, 0, 4096, 0, 1, EV_NONE, 0, 1},           // first sample, exactly 1 g
		'{0, 4096, 0, 0, 0, EV_NONE, 0, 0},           // moving by change only, peak at time zero
		'{0, 4096, 0, 3, 1, EV_NONE, 0, 1},           // still, clears lift run and ring
		'{4096, 0, 0, 5, 0, EV_NONE, 0, 0},
		'{0, 0, 4096, 7, 0, EV_NONE, 0, 0},           // second recent peak
		'{32767, 32767, 32767, 20, 1, EV_NONE, 1, 0}, // disarmed, cooling
		'{-32768, -32768, -32768, 40, 1, EV_NONE, 1, 0},
		'{0, 0, 4096, 50, 1, EV_NONE, 1, 0},
		'{0, 0, 4096, 60, 1, EV_NONE, 0, 0},
		'{0, 0, 2867, 70, 1, EV_NONE, 0, 0},          // lower band edge, change at threshold
		'{0, 0, 2866, 80, 1, EV_NONE, 1, 0},
		'{0, 0, 4095, 90, 1, EV_NONE, 0, 0},
		'{0, 0, 5324, 100, 1, EV_NONE, 0, 0},
		'{0, 0, 5325, 110, 1, EV_NONE, 0, 0},         // upper band edge
		'{0, 0, 5326, 120, 1, EV_NONE, 1, 0},
		'{0, 0, 4096, 32'hFFFF_FFFF, 1, EV_NONE, 1, 0},
		'{0, 0, 4096, 32'hFFFF_FFFF, 1, EV_NONE, 0, 0}
	};

	accel_shake_lift_detector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("ERROR: %s", msg);
		end
	endtask

	// Classify one sample, advance the predicted state, return the result
	function automatic status_t predict_status(input sample_t smp);
		longint      x, y, z, dx, dy, dz, thr, mag2, hi, lo;
		bit          moving;
		logic [1:0]  ev;
		int unsigned peaks;
		logic [31:0] now, age;
		status_t     res;
		x = smp.x;
		y = smp.y;
		z = smp.z;
		now = smp.t;
		thr = cfg_thr;
		mag2 = x * x + y * y + z * z;
		hi = ONE_G + thr;
		lo = ONE_G - thr;
		moving = 1'b0;
		if (have_last) begin
			dx = x - last_x;
			dy = y - last_y;
			dz = z - last_z;
			if (dx * dx + dy * dy + dz * dz > thr * thr) moving = 1'b1;
		end
		if (mag2 > hi * hi) moving = 1'b1;
		if (lo > 0 && mag2 < lo * lo) moving = 1'b1;
		last_x = smp.x;
		last_y = smp.y;
		last_z = smp.z;
		have_last = 1'b1;
		ev = EV_NONE;
		peaks = 0;
		if (!moving) begin
			if (still_cnt < 255) still_cnt++;
			if (still_cnt >= cfg_rearm) arm_q = 1'b1;
			lift_cnt = 0;
			peak_ring = '{default: '0};
		end else begin
			still_cnt = 0;
			if (arm_q && now >= quiet_until) begin
				peak_ring[ring_ptr] = now;
				ring_ptr = (ring_ptr + 1) % PEAK_SLOTS;
				for (int i = 0; i < PEAK_SLOTS; i++) begin
					age = now - peak_ring[i];
					if (peak_ring[i] != 0 && age < cfg_window) peaks++;
				end
				if (peaks >= cfg_peaks) begin
					arm_q = 1'b0;
					lift_cnt = 0;
					quiet_until = now + cfg_cooldown;
					peak_ring = '{default: '0};
					ev = EV_SHAKE;
				end else begin
					if (lift_cnt < 255) lift_cnt++;
					if (lift_cnt >= cfg_lift) begin
						arm_q = 1'b0;
						lift_cnt = 0;
						quiet_until = now + cfg_cooldown;
						ev = EV_LIFT;
					end
				end
			end
		end
		res = '0;
		res.ev = ev;
		res.moving = moving;
		res.armed = arm_q;
		return res;
	endfunction

	// Offer one request in the current burst; record the expected result on acceptance
	task automatic send_item(input sample_t smp, input bit typed, input status_t typed_st);
		status_t pred;
		int      gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		s_tdata = smp;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = predict_status(smp);
		status_due.push_back(typed ? typed_st : pred);
		burst_left--;
		@(negedge clk);
	endtask

	// Write one register, then read it back
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (rd !== val) begin
			flag_error($sformatf("register %0d read back %0h, wrote %0h", idx, rd, val));
		end
		case (idx)
			REG_MOTION_THRESHOLD: cfg_thr = val;
			REG_REARM_STILL:      cfg_rearm = val;
			REG_LIFT_SAMPLES:     cfg_lift = val;
			REG_SHAKE_PEAKS:      cfg_peaks = val;
			REG_SHAKE_WINDOW:     cfg_window = val;
			REG_EVENT_COOLDOWN:   cfg_cooldown = val;
			default: ;
		endcase
	endtask

	task automatic apply_config(input int unsigned thr, rearm, lift, peaks, win, cd);
		write_reg(REG_MOTION_THRESHOLD, thr);
		write_reg(REG_REARM_STILL, rearm);
		write_reg(REG_LIFT_SAMPLES, lift);
		write_reg(REG_SHAKE_PEAKS, peaks);
		write_reg(REG_SHAKE_WINDOW, win);
		write_reg(REG_EVENT_COOLDOWN, cd);
	endtask

	// Stop offering and wait until every result is back and the pipeline is empty
	task automatic settle();
		s_tvalid = 1'b0;
		burst_left = 0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Still samples sit near 1 g on one axis with small jitter; moving ones span the range
	function automatic sample_t make_sample(input bit still, input int axis, input int jit,
		input logic [31:0] t);
		int      v [3];
		sample_t smp;
		for (int i = 0; i < 3; i++) begin
			if (still) begin
				v[i] = $urandom_range(0, 2 * jit) - jit;
			end else if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: v[i] = -32768;
					1: v[i] = 32767;
					default: v[i] = 0;
				endcase
			end else begin
				v[i] = int'($urandom_range(0, 65535)) - 32768;
			end
		end
		if (still) v[axis % 3] += (axis < 3) ? ONE_G : -ONE_G;
		smp.x = SAMPLE_BITS'(v[0]);
		smp.y = SAMPLE_BITS'(v[1]);
		smp.z = SAMPLE_BITS'(v[2]);
		smp.t = t;
		return smp;
	endfunction

	// Episodes of still runs that re-arm, then moving bursts, with noise mixed in
	task automatic run_phase(input int n_items);
		int      done, k, axis, run_len, jit;
		bit      noisy;
		status_t none;
		none = '0;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 2) == 0) begin
				g_time = g_time + cfg_cooldown + $urandom_range(1, 50);
			end else if ($urandom_range(0, 15) == 0) begin
				g_time = $urandom;
			end
			axis = $urandom_range(0, 5);
			jit = cfg_thr / 4;
			run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cfg_rearm)
				: cfg_rearm + $urandom_range(0, 3);
			for (k = 0; k < run_len && done < n_items; k++) begin
				g_time = g_time + $urandom_range(1, 40);
				noisy = ($urandom_range(0, 9) == 0);
				send_item(make_sample(!noisy, axis, jit, g_time), 1'b0, none);
				done++;
			end
			run_len = $urandom_range(1, cfg_lift + 2);
			for (k = 0; k < run_len && done < n_items; k++) begin
				g_time = g_time + (($urandom_range(0, 3) == 0)
					? $urandom_range(0, cfg_window + 8) : $urandom_range(0, 12));
				send_item(make_sample(1'b0, axis, jit, g_time), 1'b0, none);
				done++;
			end
		end
	endtask

	// Result receiver: its own stall pattern plus long hold-offs on request
	initial begin
		int       hold_left, mode_left, holds_taken, pat;
		rx_mode_t rx_mode;
		hold_left = 0;
		mode_left = 0;
		holds_taken = 0;
		pat = 0;
		rx_mode = RX_STEADY;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_taken != hold_asks) begin
				holds_taken = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			pat++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY:  m_tready = 1'b1;
					RX_COIN:    m_tready = ($urandom_range(0, 1) == 1);
					RX_SPARSE:  m_tready = ($urandom_range(0, 3) == 0);
					default:    m_tready = (pat % 5) < 3;
				endcase
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		status_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (status_due.size() == 0) begin
				flag_error($sformatf("result %0d arrived with no request pending", result_count));
			end else begin
				want = status_due.pop_front();
				if (got.ev !== want.ev || got.moving !== want.moving
					|| got.armed !== want.armed) begin
					flag_error($sformatf({"result %0d: expected event %0d moving %0b armed %0b,",
						" got event %0d moving %0b armed %0b"}, result_count, want.ev,
						want.moving, want.armed, got.ev, got.moving, got.armed));
				end
			end
			result_count++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** accel_shake_lift_detector: FAILED **");
			$finish;
		end
	end

	initial begin
		sample_t smp;
		status_t typed_st;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		g_time = 32'd1000;
		cfg_thr = 1229;
		cfg_rearm = 50;
		cfg_lift = 5;
		cfg_peaks = 2;
		cfg_window = 1000;
		cfg_cooldown = 30000;
		last_x = '0;
		last_y = '0;
		last_z = '0;
		have_last = 1'b0;
		arm_q = 1'b1;
		lift_cnt = 0;
		still_cnt = 0;
		peak_ring = '{default: '0};
		ring_ptr = 0;
		quiet_until = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table under reset configuration
		foreach (dir_rows[i]) begin
			smp.x = dir_rows[i].x;
			smp.y = dir_rows[i].y;
			smp.z = dir_rows[i].z;
			smp.t = dir_rows[i].t;
			typed_st = '0;
			typed_st.ev = dir_rows[i].ev;
			typed_st.moving = dir_rows[i].mv;
			typed_st.armed = dir_rows[i].arm;
			send_item(smp, dir_rows[i].chk, typed_st);
		end
		settle();

		// Random phases; long receiver hold-offs in some of them
		hold_asks++;
		run_phase(150);
		settle();
		apply_config(0, 1, 1, 1, 0, 0);
		run_phase(100);
		settle();
		apply_config(32767, 255, 255, 8, 65535, 1048575);
		hold_asks++;
		run_phase(300);
		settle();
		apply_config($urandom_range(1, 3000), $urandom_range(1, 8), $urandom_range(1, 6),
			$urandom_range(1, 8), $urandom_range(0, 2000), $urandom_range(0, 5000));
		run_phase(150);
		settle();
		apply_config(5000, 2, 2, 8, 0, 100);
		run_phase(100);
		settle();
		apply_config(4096, 5, 3, 2, 50, 2000);
		hold_asks++;
		run_phase(150);

		settle();
		repeat (16) @(posedge clk);
		if (err_count == 0 && status_due.size() == 0) begin
			$display("** accel_shake_lift_detector: PASSED **");
		end else begin
			$display("** accel_shake_lift_detector: FAILED **");
		end
		$finish;
	end

endmodule
